[sv/dlcq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the delta-list callout queue.
// No dependencies; used by the controller, the datapath and the top level.
package dlcq_pkg;

   localparam int DELAY_W         = 15;
   localparam int HANDLER_W       = 8;
   localparam int ARG_W           = 16;
   localparam int TABLE_SLOTS_DEF = 32;

   typedef struct packed {
      logic [DELAY_W-1:0]   delta;
      logic [HANDLER_W-1:0] handler;
      logic [ARG_W-1:0]     argument;
   } entry_type;

   // scan pointer operations
   typedef logic [2:0] ptr_op_type;
   localparam ptr_op_type PTR_HOLD = 3'd0;
   localparam ptr_op_type PTR_ZERO = 3'd1;
   localparam ptr_op_type PTR_INC  = 3'd2;
   localparam ptr_op_type PTR_DEC  = 3'd3;
   localparam ptr_op_type PTR_LAST = 3'd4;
   localparam ptr_op_type PTR_AUX  = 3'd5;

   // position / fired-count register operations
   typedef logic [1:0] aux_op_type;
   localparam aux_op_type AUX_HOLD  = 2'd0;
   localparam aux_op_type AUX_PTR   = 2'd1;
   localparam aux_op_type AUX_COUNT = 2'd2;

   // table write operations
   typedef logic [2:0] wr_op_type;
   localparam wr_op_type WR_NONE    = 3'd0;
   localparam wr_op_type WR_SHIFT   = 3'd1;
   localparam wr_op_type WR_INSERT  = 3'd2;
   localparam wr_op_type WR_DEC     = 3'd3;
   localparam wr_op_type WR_COMPACT = 3'd4;

   // entry count operations
   typedef logic [1:0] cnt_op_type;
   localparam cnt_op_type CNT_HOLD = 2'd0;
   localparam cnt_op_type CNT_INC  = 2'd1;
   localparam cnt_op_type CNT_SUB  = 2'd2;

   typedef struct packed {
      logic       latch;
      ptr_op_type ptr_op;
      aux_op_type aux_op;
      logic       t_sub;
      wr_op_type  wr_op;
      cnt_op_type cnt_op;
      logic       out_fire;
      logic       out_ovf;
   } cmd_type;

   typedef struct packed {
      logic rd_delta_zero;
      logic rd_delta_one;
      logic rd_le_t;
      logic ptr_lt_count;
      logic ptr_is_last;
      logic ptr_eq_aux;
      logic ptr_final_emit;
      logic ptr_zero;
      logic count_full;
      logic count_zero;
      logic aux_eq_count;
      logic out_free;
   } status_type;

endpackage

[sv/dlcq_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine for the callout queue.
// Depends on dlcq_pkg; drives dlcq_datapath through cmd_type / status_type.
module dlcq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_kind,
   output logic                 req_ready,
   input  dlcq_pkg::status_type stat,
   output dlcq_pkg::cmd_type    cmd
);
   import dlcq_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_OVF     = 4'd1;
   localparam logic [3:0] S_WALK    = 4'd2;
   localparam logic [3:0] S_SHIFT   = 4'd3;
   localparam logic [3:0] S_INSERT  = 4'd4;
   localparam logic [3:0] S_FIND    = 4'd5;
   localparam logic [3:0] S_ZERO    = 4'd6;
   localparam logic [3:0] S_EMIT    = 4'd7;
   localparam logic [3:0] S_COMPACT = 4'd8;

   logic [3:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.ptr_op   = PTR_HOLD;
      cmd.aux_op   = AUX_HOLD;
      cmd.wr_op    = WR_NONE;
      cmd.cnt_op   = CNT_HOLD;
      case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.ptr_op = PTR_ZERO;
            if (req_valid) begin
               cmd.latch = 1'b1;
               if (req_kind) begin
                  state_in = stat.count_full ? S_OVF : S_WALK;
               end else begin
                  state_in = stat.count_zero ? S_IDLE : S_FIND;
               end
            end
         end
         S_OVF: begin
            cmd.ptr_op = PTR_ZERO;
            if (stat.out_free) begin
               cmd.out_ovf = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_WALK: begin
            if (stat.ptr_lt_count && stat.rd_le_t) begin
               cmd.t_sub  = 1'b1;
               cmd.ptr_op = PTR_INC;
            end else begin
               cmd.aux_op = AUX_PTR;
               if (stat.ptr_lt_count) begin
                  cmd.ptr_op = PTR_LAST;
                  state_in   = S_SHIFT;
               end else begin
                  state_in = S_INSERT;
               end
            end
         end
         S_SHIFT: begin
            cmd.wr_op = WR_SHIFT;
            if (stat.ptr_eq_aux) begin
               state_in = S_INSERT;
            end else begin
               cmd.ptr_op = PTR_DEC;
            end
         end
         S_INSERT: begin
            cmd.wr_op  = WR_INSERT;
            cmd.cnt_op = CNT_INC;
            cmd.ptr_op = PTR_ZERO;
            state_in   = S_IDLE;
         end
         S_FIND: begin
            if (stat.rd_delta_zero) begin
               if (stat.ptr_is_last) begin
                  cmd.aux_op = AUX_COUNT;
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = S_EMIT;
               end else begin
                  cmd.ptr_op = PTR_INC;
               end
            end else begin
               cmd.wr_op = WR_DEC;
               if (stat.rd_delta_one) begin
                  if (stat.ptr_is_last) begin
                     cmd.aux_op = AUX_COUNT;
                     cmd.ptr_op = PTR_ZERO;
                     state_in   = S_EMIT;
                  end else begin
                     cmd.ptr_op = PTR_INC;
                     state_in   = S_ZERO;
                  end
               end else begin
                  cmd.aux_op = AUX_PTR;
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = stat.ptr_zero ? S_IDLE : S_EMIT;
               end
            end
         end
         S_ZERO: begin
            if (stat.rd_delta_zero) begin
               if (stat.ptr_is_last) begin
                  cmd.aux_op = AUX_COUNT;
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = S_EMIT;
               end else begin
                  cmd.ptr_op = PTR_INC;
               end
            end else begin
               cmd.aux_op = AUX_PTR;
               cmd.ptr_op = PTR_ZERO;
               state_in   = S_EMIT;
            end
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_fire = 1'b1;
               if (stat.ptr_final_emit) begin
                  if (stat.aux_eq_count) begin
                     cmd.cnt_op = CNT_SUB;
                     cmd.ptr_op = PTR_ZERO;
                     state_in   = S_IDLE;
                  end else begin
                     cmd.ptr_op = PTR_AUX;
                     state_in   = S_COMPACT;
                  end
               end else begin
                  cmd.ptr_op = PTR_INC;
               end
            end
         end
         S_COMPACT: begin
            cmd.wr_op = WR_COMPACT;
            if (stat.ptr_is_last) begin
               cmd.cnt_op = CNT_SUB;
               cmd.ptr_op = PTR_ZERO;
               state_in   = S_IDLE;
            end else begin
               cmd.ptr_op = PTR_INC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

[sv/dlcq_datapath.sv]
`timescale 1ns / 1ps
// Entry table, scan pointer, remaining-delay register and result register.
// Depends on dlcq_pkg; commanded by dlcq_ctrl.
module dlcq_datapath #(
   parameter int TABLE_SLOTS = dlcq_pkg::TABLE_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dlcq_pkg::cmd_type              cmd,
   output dlcq_pkg::status_type           stat,
   input  logic [dlcq_pkg::DELAY_W-1:0]   req_delay,
   input  logic [dlcq_pkg::HANDLER_W-1:0] req_handler,
   input  logic [dlcq_pkg::ARG_W-1:0]     req_argument,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dlcq_pkg::HANDLER_W-1:0] rsp_fired_handler,
   output logic [dlcq_pkg::ARG_W-1:0]     rsp_fired_argument,
   output logic                           rsp_last,
   output logic                           rsp_overflow
);
   import dlcq_pkg::*;

   localparam int         AW  = $clog2(TABLE_SLOTS);
   localparam logic [AW-1:0] CAP = AW'(TABLE_SLOTS - 1);

   entry_type mem [TABLE_SLOTS];
   entry_type rd_ff;

   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        aux_ff, aux_in;
   logic [AW-1:0]        count_ff, count_in;
   logic [DELAY_W-1:0]   t_ff, t_in;
   logic [HANDLER_W-1:0] hnd_ff;
   logic [ARG_W-1:0]     arg_ff;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   entry_type            wr_data;

   logic                 rsp_valid_ff;
   logic [HANDLER_W-1:0] rsp_hnd_ff;
   logic [ARG_W-1:0]     rsp_arg_ff;
   logic                 rsp_last_ff;
   logic                 rsp_ovf_ff;

   // pointer next value; the table is read at it so rd_ff tracks ptr_ff
   always_comb begin
      case (cmd.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_ZERO: ptr_in = '0;
         PTR_INC:  ptr_in = ptr_ff + 1'b1;
         PTR_DEC:  ptr_in = ptr_ff - 1'b1;
         PTR_LAST: ptr_in = count_ff - 1'b1;
         PTR_AUX:  ptr_in = aux_ff;
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      case (cmd.aux_op)
         AUX_HOLD:  aux_in = aux_ff;
         AUX_PTR:   aux_in = ptr_ff;
         AUX_COUNT: aux_in = count_ff;
         default:   aux_in = aux_ff;
      endcase
   end

   always_comb begin
      case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + 1'b1;
         CNT_SUB:  count_in = count_ff - aux_ff;
         default:  count_in = count_ff;
      endcase
   end

   always_comb begin
      if (cmd.latch) begin
         t_in = req_delay;
      end else if (cmd.t_sub) begin
         t_in = t_ff - rd_ff.delta;
      end else begin
         t_in = t_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b1;
      wr_addr = ptr_ff;
      wr_data = rd_ff;
      case (cmd.wr_op)
         WR_NONE: begin
            wr_en = 1'b0;
         end
         WR_SHIFT: begin
            // the entry that ends up behind the new one loses the new delay
            wr_addr = ptr_ff + 1'b1;
            if (ptr_ff == aux_ff) begin
               wr_data.delta = rd_ff.delta - t_ff;
            end
         end
         WR_INSERT: begin
            wr_addr          = aux_ff;
            wr_data.delta    = t_ff;
            wr_data.handler  = hnd_ff;
            wr_data.argument = arg_ff;
         end
         WR_DEC: begin
            wr_data.delta = rd_ff.delta - 1'b1;
         end
         WR_COMPACT: begin
            wr_addr = ptr_ff - aux_ff;
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ptr_ff   <= '0;
      end else begin
         count_ff <= count_in;
         ptr_ff   <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      aux_ff <= aux_in;
      t_ff   <= t_in;
      if (cmd.latch) begin
         hnd_ff <= req_handler;
         arg_ff <= req_argument;
      end
   end

   always_comb begin
      stat.rd_delta_zero  = (rd_ff.delta == '0);
      stat.rd_delta_one   = (rd_ff.delta == DELAY_W'(1));
      stat.rd_le_t        = (rd_ff.delta <= t_ff);
      stat.ptr_lt_count   = (ptr_ff < count_ff);
      stat.ptr_is_last    = (ptr_ff == AW'(count_ff - 1'b1));
      stat.ptr_eq_aux     = (ptr_ff == aux_ff);
      stat.ptr_final_emit = (ptr_ff == AW'(aux_ff - 1'b1));
      stat.ptr_zero       = (ptr_ff == '0);
      stat.count_full     = (count_ff == CAP);
      stat.count_zero     = (count_ff == '0);
      stat.aux_eq_count   = (aux_ff == count_ff);
      stat.out_free       = !rsp_valid_ff || rsp_ready;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_fire || cmd.out_ovf) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_ovf) begin
         rsp_hnd_ff  <= hnd_ff;
         rsp_arg_ff  <= arg_ff;
         rsp_last_ff <= 1'b1;
         rsp_ovf_ff  <= 1'b1;
      end else if (cmd.out_fire) begin
         rsp_hnd_ff  <= rd_ff.handler;
         rsp_arg_ff  <= rd_ff.argument;
         rsp_last_ff <= stat.ptr_final_emit;
         rsp_ovf_ff  <= 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_fired_handler  = rsp_hnd_ff;
   assign rsp_fired_argument = rsp_arg_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_overflow       = rsp_ovf_ff;

endmodule

[sv/delta_list_callout_queue.sv]
`timescale 1ns / 1ps
// Top level of the delta-list callout queue: controller plus datapath.
// Depends on dlcq_pkg, dlcq_ctrl and dlcq_datapath.
//
// Callout timer queue holding up to TABLE_SLOTS-1 pending callouts, sorted
// by expiry, each storing its delay relative to the entry in front of it.
// A schedule request (kind=1) walks the list, shifts later entries up and
// inserts the new entry; it produces no result unless the table is full, in
// which case the request is dropped and one result echoes handler and
// argument with overflow=1 and last=1. A tick request (kind=0) decrements the
// first positive delta, then delivers every leading zero-delta entry in
// order (last=1 on the final one) and compacts the table. Each request takes
// one table entry per cycle, except while it stalls on the result side,
// through a table with one write port and a registered read port. One
// request is processed at a time; the next is accepted once the current one
// has finished, even while its last result still waits in the output
// register. No clearing pass is needed after reset.
module delta_list_callout_queue #(
   parameter int TABLE_SLOTS = dlcq_pkg::TABLE_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [dlcq_pkg::DELAY_W-1:0]   req_delay,
   input  logic [dlcq_pkg::HANDLER_W-1:0] req_handler,
   input  logic [dlcq_pkg::ARG_W-1:0]     req_argument,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [dlcq_pkg::HANDLER_W-1:0] rsp_fired_handler,
   output logic [dlcq_pkg::ARG_W-1:0]     rsp_fired_argument,
   output logic                           rsp_last,
   output logic                           rsp_overflow
);
   import dlcq_pkg::*;

   cmd_type    cmd;
   status_type stat;

   dlcq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dlcq_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_delay          (req_delay),
      .req_handler        (req_handler),
      .req_argument       (req_argument),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_fired_handler  (rsp_fired_handler),
      .rsp_fired_argument (rsp_fired_argument),
      .rsp_last           (rsp_last),
      .rsp_overflow       (rsp_overflow)
   );

`ifndef SYNTH
   // a dropped schedule is always a single, final result
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> rsp_last)
      else $error("overflow result without last");

   // the table is never written while a new request can be taken
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_op != WR_NONE) |-> !req_ready)
      else $error("table write while idle");

   // a schedule into a full table leaves table and count alone
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind && stat.count_full) |=>
      (cmd.wr_op == WR_NONE && cmd.cnt_op == CNT_HOLD))
      else $error("full table modified by schedule");

   // the count never grows past capacity
   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      (cmd.cnt_op == CNT_INC) |-> !stat.count_full)
      else $error("insert into full table");

   // a result is only loaded when the output register can take it
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_fire || cmd.out_ovf) |-> stat.out_free)
      else $error("result register overwritten");
`endif

endmodule
